/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked concurrent check, quiet while reset is asserted.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication check, quiet while reset is asserted.
`define ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/nfpp_pkg.sv */
`timescale 1ns / 1ps
package nfpp_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FIELD_WIDTH = 32;

    typedef logic [FIELD_WIDTH-1:0] field_t;
    typedef logic [VALUE_WIDTH-1:0] value_t;

endpackage

/* rtl/nfpp_if.sv */
`timescale 1ns / 1ps
interface start_if
    import nfpp_pkg::*;
();
    logic   valid;
    logic   ready;
    field_t start_value;

    modport source (output valid, output start_value, input ready);
    modport sink (input valid, input start_value, output ready);
endinterface

interface prime_if
    import nfpp_pkg::*;
();
    logic   valid;
    logic   ready;
    field_t probable_prime;

    modport source (output valid, output probable_prime, input ready);
    modport sink (input valid, input probable_prime, output ready);
endinterface

/* rtl/next_fermat_probable_prime.sv */
`timescale 1ns / 1ps
// channel   dir  payload               word accepted when
// start     in   start_value[31:0]     start.valid && start.ready
// result    out  probable_prime[31:0]  result.valid && result.ready
//
// Each candidate runs a test step, then a base-2 exponentiation (W = VALUE_WIDTH):
// W bit-serial modular squarings, each followed by a doubling step, then a check.
// Candidate one passes at the test step; a word repeats this for every candidate tried.
// start is ready only while idle; the result register frees it to take the next word.
// A stalled result holds in the output register; reset clears control, not data.
`include "assert_macros.svh"

module next_fermat_probable_prime
    import nfpp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    start_if.sink    start,
    prime_if.source  result
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TEST  = 3'd1;
    localparam logic [2:0] S_SQR   = 3'd2;
    localparam logic [2:0] S_DBL   = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam value_t ONE = VALUE_WIDTH'(1);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] sq_cnt_reg, bit_cnt_reg;
    logic             out_valid_reg;
    field_t           out_data_reg;

    value_t cand_reg;
    value_t acc_reg;
    value_t r_reg;
    value_t mul_sh_reg;
    value_t exp_sh_reg;

    value_t sq_dbl, sq_add, dbl_res, cand_inc, start_low;
    logic   release_ok;

    function automatic value_t mod_dbl(value_t a, value_t n);
        logic [VALUE_WIDTH:0] t;
        t = {a, 1'b0};
        if (t >= {1'b0, n})
        begin
            t = t - {1'b0, n};
        end
        return t[VALUE_WIDTH-1:0];
    endfunction

    function automatic value_t mod_add(value_t a, value_t b, value_t n);
        logic [VALUE_WIDTH:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= {1'b0, n})
        begin
            t = t - {1'b0, n};
        end
        return t[VALUE_WIDTH-1:0];
    endfunction

    // one multiplier bit per cycle, MSB first: r = 2r + bit*acc (mod n)
    assign sq_dbl  = mod_dbl(r_reg, cand_reg);
    assign sq_add  = mul_sh_reg[VALUE_WIDTH-1] ? mod_add(sq_dbl, acc_reg, cand_reg) : sq_dbl;
    // base is 2, so a multiply step is a modular doubling
    assign dbl_res = exp_sh_reg[VALUE_WIDTH-1] ? mod_dbl(r_reg, cand_reg) : r_reg;

    assign cand_inc   = (cand_reg + ONE == '0) ? ONE : cand_reg + ONE;
    assign start_low  = start.start_value[VALUE_WIDTH-1:0];
    assign release_ok = !out_valid_reg || result.ready;

    assign start.ready           = (state_reg == S_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.probable_prime = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start.valid)
                begin
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                state_next = (cand_reg == ONE) ? S_DONE : S_SQR;
            end
            S_SQR:
            begin
                if (sq_cnt_reg == CNT_LAST)
                begin
                    state_next = S_DBL;
                end
            end
            S_DBL:
            begin
                state_next = (bit_cnt_reg == CNT_LAST) ? S_CHECK : S_SQR;
            end
            S_CHECK:
            begin
                state_next = (acc_reg == ONE) ? S_DONE : S_TEST;
            end
            S_DONE:
            begin
                if (release_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sq_cnt_reg    <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_TEST)
            begin
                sq_cnt_reg  <= '0;
                bit_cnt_reg <= '0;
            end
            else if (state_reg == S_SQR)
            begin
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
            end
            else if (state_reg == S_DBL)
            begin
                sq_cnt_reg  <= '0;
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end

            if (state_reg == S_DONE && release_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start.valid)
                begin
                    cand_reg <= (start_low == '0) ? ONE : start_low;
                end
            end
            S_TEST:
            begin
                acc_reg    <= ONE;
                mul_sh_reg <= ONE;
                r_reg      <= '0;
                exp_sh_reg <= cand_reg - ONE;
            end
            S_SQR:
            begin
                r_reg      <= sq_add;
                mul_sh_reg <= {mul_sh_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            S_DBL:
            begin
                acc_reg    <= dbl_res;
                mul_sh_reg <= dbl_res;
                r_reg      <= '0;
                exp_sh_reg <= {exp_sh_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            S_CHECK:
            begin
                if (acc_reg != ONE)
                begin
                    cand_reg <= cand_inc;
                end
            end
            S_DONE:
            begin
                if (release_ok)
                begin
                    out_data_reg <= FIELD_WIDTH'(cand_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    `ASSERT_IMP(a_partial_reduced, state_reg == S_SQR || state_reg == S_DBL, r_reg < cand_reg, "partial product not reduced below modulus")
    `ASSERT_IMP(a_acc_reduced, state_reg == S_CHECK, acc_reg < cand_reg, "power not reduced below modulus")
    `ASSERT_CLK(a_accept_starts, (start.valid && start.ready) |=> (state_reg == S_TEST), "accepted word did not start a test")
    `ASSERT_IMP(a_no_zero_cand, state_reg != S_IDLE, cand_reg != '0, "candidate zero under test")
    `ASSERT_IMP(a_result_valid, result.valid, result.probable_prime != 0 && result.probable_prime != 2, "result cannot pass the test")

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import nfpp_pkg::*;

    localparam int RANDOM_WORDS = 384;
    localparam int QUIET_TAIL   = 40;
    localparam int LONG_HOLD    = 20000;
    localparam int SETTLE       = 2200;

    typedef struct {
        field_t value;
        bit     wait_drain;
    } start_word_t;

    logic clk = 1'b0;
    logic rst_n;

    start_if start_ch ();
    prime_if result_ch ();

    next_fermat_probable_prime u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_ch),
        .result (result_ch)
    );

    always #1 clk = ~clk;

    start_word_t start_words[$];
    field_t      expected_primes[$];
    int          total_words = 0;
    int          words_accepted = 0;
    int          primes_seen = 0;
    int          mismatches = 0;
    logic        start_taken = 1'b0;
    int          start_gap = 0;
    int          ready_gap = 0;
    int          hold_cnt = 0;
    bit          hold_done = 1'b0;

    // 2^(n-1) mod n == 1, square-and-multiply from the low exponent bit up
    function automatic bit passes_base2(value_t n);
        bit [63:0] modulus;
        bit [63:0] acc;
        bit [63:0] square;
        bit [63:0] exponent;
        modulus  = 64'(n);
        acc      = 64'd1;
        square   = 64'd2 % modulus;
        exponent = modulus - 64'd1;
        while (exponent != 64'd0)
        begin
            if (exponent[0])
                acc = (acc * square) % modulus;
            square   = (square * square) % modulus;
            exponent = exponent >> 1;
        end
        return acc == 64'd1;
    endfunction

    function automatic field_t next_probable_prime(field_t seed);
        value_t cand;
        cand = seed[VALUE_WIDTH-1:0];
        if (cand == '0)
            cand = 1;
        while (!passes_base2(cand))
        begin
            cand = cand + 1'b1;
            // counter wraps to zero, which is taken as one and passes
            if (cand == '0)
                cand = 1;
        end
        return field_t'(cand);
    endfunction

    task automatic queue_word(field_t value, bit wait_drain);
        start_word_t word;
        word.value      = value;
        word.wait_drain = wait_drain;
        start_words.push_back(word);
    endtask

    // sample both channels at the rising edge
    always @(posedge clk)
    begin : watch_channels
        field_t want;
        start_taken <= rst_n && start_ch.valid && start_ch.ready;
        if (rst_n && start_ch.valid && start_ch.ready)
        begin
            expected_primes.push_back(next_probable_prime(start_ch.start_value));
            words_accepted++;
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            primes_seen++;
            if (expected_primes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: probable_prime=%0d",
                             result_ch.probable_prime);
            end
            else
            begin
                want = expected_primes.pop_front();
                if (result_ch.probable_prime !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("probable_prime mismatch: expected %0d, got %0d",
                                 want, result_ch.probable_prime);
                end
            end
        end
    end

    // sender: new word or idle burst once the previous word is gone
    always @(negedge clk)
    begin : drive_start
        start_word_t word;
        if (rst_n)
        begin
            if (!start_ch.valid || start_taken)
            begin
                if (start_gap != 0)
                begin
                    start_gap <= start_gap - 1;
                    start_ch.valid <= 1'b0;
                end
                else if (start_words.size() != 0 &&
                         !(start_words[0].wait_drain && expected_primes.size() != 0))
                begin
                    if (start_words.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
                    begin
                        start_gap <= $urandom_range(0, 14);
                        start_ch.valid <= 1'b0;
                    end
                    else
                    begin
                        word = start_words.pop_front();
                        start_ch.valid <= 1'b1;
                        start_ch.start_value <= word.value;
                    end
                end
                else
                begin
                    start_ch.valid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold-off so the result register fills and start stalls
    always @(negedge clk)
    begin : long_hold
        if (rst_n)
        begin
            if (hold_cnt != 0)
                hold_cnt <= hold_cnt - 1;
            else if (!hold_done && primes_seen >= 40)
            begin
                hold_cnt  <= LONG_HOLD;
                hold_done <= 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin : drive_ready
        if (rst_n)
        begin
            if (hold_cnt != 0)
                result_ch.ready <= 1'b0;
            else if (ready_gap != 0)
            begin
                ready_gap <= ready_gap - 1;
                result_ch.ready <= 1'b0;
            end
            else if (primes_seen < total_words - QUIET_TAIL && $urandom_range(0, 7) == 0)
            begin
                ready_gap <= $urandom_range(0, 14);
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : run
        int pick;
        field_t value;
        start_ch.valid       = 1'b0;
        start_ch.start_value = '0;
        result_ch.ready      = 1'b0;
        rst_n                = 1'b0;

        // zero start, one, rejected two, pseudoprimes, top of range and wrap
        queue_word(32'd0, 1'b0);
        queue_word(32'd1, 1'b0);
        queue_word(32'd2, 1'b0);
        queue_word(32'd3, 1'b0);
        queue_word(32'd4, 1'b0);
        queue_word(32'd340, 1'b0);
        queue_word(32'd341, 1'b0);
        queue_word(32'd560, 1'b0);
        queue_word(32'd561, 1'b0);
        queue_word(32'h7FFF_FFFF, 1'b0);
        queue_word(32'h8000_0000, 1'b0);
        queue_word(32'hFFFF_FFFB, 1'b0);
        queue_word(32'hFFFF_FFFC, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b0);
        queue_word(32'hAAAA_AAAA, 1'b0);
        queue_word(32'h5555_5555, 1'b0);

        // mostly small starts: every candidate above one costs a full exponentiation
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                value = $urandom_range(0, 255);
            else if (pick < 92)
                value = $urandom_range(0, 65535);
            else if (pick < 95)
                value = $urandom_range(0, 16);
            else if (pick < 97)
                value = 32'hFFFF_FFF0 | $urandom_range(0, 15);
            else
                value = $urandom();
            queue_word(value, i == 0 || i == RANDOM_WORDS / 2);
        end
        total_words = start_words.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (words_accepted != total_words || expected_primes.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        if (mismatches == 0)
            $display("[next_fermat_probable_prime] OK");
        else
            $display("[next_fermat_probable_prime] ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #200_000_000;
        $display("[next_fermat_probable_prime] ERROR");
        $finish;
    end

endmodule

/* next_fermat_probable_prime.f */
+incdir+rtl
rtl/nfpp_pkg.sv
rtl/nfpp_if.sv
rtl/next_fermat_probable_prime.sv
sim/testbench.sv
